FILE: rtl/core/lcdt_pkg.sv
package lcdt_pkg;

  localparam int unsigned AccW = 10;
  localparam int unsigned LineW = 8;
  localparam int unsigned ElapsedW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned LineCyclesDefault = 456;

  localparam logic [LineW-1:0] LastVisibleLine = 8'd143;
  localparam logic [LineW-1:0] FirstVblankLine = 8'd144;
  localparam logic [LineW-1:0] LastLine = 8'd153;
  localparam logic [AccW-1:0] OamEndCycle = 10'd80;
  localparam logic [AccW-1:0] XferEndCycle = 10'd252;

  localparam logic [CfgIdxW-1:0] CfgDisplayEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLineCompare = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHblankIrqEnable = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgVblankIrqEnable = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOamIrqEnable = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMatchIrqEnable = 3'd5;

  typedef enum logic [1:0] {
    ModeHblank = 2'd0,
    ModeVblank = 2'd1,
    ModeOam    = 2'd2,
    ModeXfer   = 2'd3
  } lcd_mode_e;

  typedef struct packed {
    logic             display_enable;
    logic [LineW-1:0] line_compare;
    logic             hblank_irq_enable;
    logic             vblank_irq_enable;
    logic             oam_irq_enable;
    logic             match_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [AccW-1:0]  cycle_acc;
    logic [LineW-1:0] line;
    lcd_mode_e        mode;
    logic             match;
    logic             stat_line;
  } timing_state_t;

  typedef struct packed {
    lcd_mode_e        lcd_mode;
    logic [LineW-1:0] current_line;
    logic             line_match;
    logic             vblank_request;
    logic             stat_request;
    logic             render_request;
    logic [LineW-1:0] render_line;
  } result_t;

endpackage

FILE: rtl/core/lcd_line_timing_controller_unit.sv
// Scan-line and mode timing for an LCD controller.
// Each input transfer on the in_* channel carries the number of machine
// cycles elapsed since the previous one. Each accepted item produces exactly
// one result transfer on the out_* channel with the current mode, line,
// coincidence flag and the one-shot vblank, STAT and render requests.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i and takes
// effect at once; write it only while no item is in flight.
// An accepted item is held in the input register; once the output register is
// free, its result is registered there. Throughput is one item per cycle while
// the receiver does not stall, set by the single add, compare and mode decode
// between the input and result registers, also closing the timing-state loop.
// Reset clears the timing state (line 0, accumulator 0, horizontal blank),
// all configuration registers and the valid flags of both pipeline stages.
// When the receiver stalls, the result stays in the output register and one
// more item may wait in the input register; in_ready_o drops only when both
// are full.
module lcd_line_timing_controller_unit #(
  parameter int unsigned LineCycles = lcdt_pkg::LineCyclesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lcdt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lcdt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lcdt_pkg::ElapsedW-1:0]   elapsed_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      lcd_mode_o,
  output logic [lcdt_pkg::LineW-1:0]      current_line_o,
  output logic                            line_match_o,
  output logic                            vblank_request_o,
  output logic                            stat_request_o,
  output logic                            render_request_o,
  output logic [lcdt_pkg::LineW-1:0]      render_line_o
);
  import lcdt_pkg::*;

  cfg_t             cfg_q;
  timing_state_t    state_q;
  timing_state_t    state_d;
  result_t          result_q;
  result_t          result_d;
  logic             s1_valid_q;
  logic [ElapsedW-1:0] s1_elapsed_q;
  logic             out_valid_q;
  logic             out_free;
  logic             s1_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  lcdt_step #(
    .LineCycles(LineCycles)
  ) u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .elapsed_i(s1_elapsed_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDisplayEnable:   cfg_q.display_enable <= cfg_wdata_i[0];
        CfgLineCompare:     cfg_q.line_compare <= cfg_wdata_i[LineW-1:0];
        CfgHblankIrqEnable: cfg_q.hblank_irq_enable <= cfg_wdata_i[0];
        CfgVblankIrqEnable: cfg_q.vblank_irq_enable <= cfg_wdata_i[0];
        CfgOamIrqEnable:    cfg_q.oam_irq_enable <= cfg_wdata_i[0];
        CfgMatchIrqEnable:  cfg_q.match_irq_enable <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{cycle_acc: '0, line: '0, mode: ModeHblank,
                       match: 1'b0, stat_line: 1'b0};
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_elapsed_q <= elapsed_i;
    end
    if (s1_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign lcd_mode_o       = result_q.lcd_mode;
  assign current_line_o   = result_q.current_line;
  assign line_match_o     = result_q.line_match;
  assign vblank_request_o = result_q.vblank_request;
  assign stat_request_o   = result_q.stat_request;
  assign render_request_o = result_q.render_request;
  assign render_line_o    = result_q.render_line;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line <= LastLine)
    else $error("Line counter left the frame range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vblank_request_o |->
      current_line_o == FirstVblankLine && lcd_mode_o == ModeVblank)
    else $error("Vertical blank request without entering vertical blank.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && render_request_o |-> render_line_o <= LastVisibleLine)
    else $error("Render request for a line outside the visible area.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !cfg_q.display_enable |=> $stable(state_q))
    else $error("Timing state changed while the display was disabled.");

endmodule

FILE: rtl/core/lcdt_step.sv
module lcdt_step #(
  parameter int unsigned LineCycles = lcdt_pkg::LineCyclesDefault
) (
  input  lcdt_pkg::cfg_t                      cfg_i,
  input  lcdt_pkg::timing_state_t             state_i,
  input  logic [lcdt_pkg::ElapsedW-1:0]       elapsed_i,
  output lcdt_pkg::timing_state_t             state_o,
  output lcdt_pkg::result_t                   result_o
);
  import lcdt_pkg::*;

  localparam logic [AccW:0] LineCyclesW = (AccW+1)'(LineCycles);

  logic [AccW:0]    acc_sum;
  logic [AccW:0]    acc_next;
  logic             line_done;
  logic [LineW-1:0] line_next;
  logic             match_next;
  lcd_mode_e        mode_next;
  logic             cond;

  assign acc_sum   = {1'b0, state_i.cycle_acc} + (AccW+1)'(elapsed_i);
  assign line_done = acc_sum > LineCyclesW;
  assign acc_next  = line_done ? acc_sum - LineCyclesW : acc_sum;

  always_comb begin
    line_next  = state_i.line;
    match_next = state_i.match;
    if (line_done) begin
      line_next = (state_i.line == LastLine) ? '0 : state_i.line + 8'd1;
      if (line_next == LastLine) begin
        match_next = (cfg_i.line_compare == '0);
      end else begin
        match_next = (line_next == cfg_i.line_compare);
      end
    end
  end

  always_comb begin
    if (line_next >= FirstVblankLine) begin
      mode_next = ModeVblank;
    end else if (acc_next[AccW-1:0] < OamEndCycle) begin
      mode_next = ModeOam;
    end else if (acc_next[AccW-1:0] < XferEndCycle) begin
      mode_next = ModeXfer;
    end else begin
      mode_next = ModeHblank;
    end
  end

  assign cond = (cfg_i.hblank_irq_enable && mode_next == ModeHblank) ||
                (cfg_i.vblank_irq_enable && mode_next == ModeVblank) ||
                (cfg_i.oam_irq_enable && mode_next == ModeOam) ||
                (cfg_i.match_irq_enable && match_next);

  always_comb begin
    state_o  = state_i;
    result_o = '{lcd_mode: state_i.mode, current_line: state_i.line,
                 line_match: state_i.match, vblank_request: 1'b0,
                 stat_request: 1'b0, render_request: 1'b0, render_line: '0};
    if (cfg_i.display_enable) begin
      state_o.cycle_acc = acc_next[AccW-1:0];
      state_o.line      = line_next;
      state_o.mode      = mode_next;
      state_o.match     = match_next;
      state_o.stat_line = cond;
      result_o.lcd_mode       = mode_next;
      result_o.current_line   = line_next;
      result_o.line_match     = match_next;
      result_o.vblank_request = line_done && (state_i.line == LastVisibleLine);
      result_o.stat_request   = cond && !state_i.stat_line;
      result_o.render_request = line_done && (state_i.line <= LastVisibleLine);
      result_o.render_line    = (line_done && (state_i.line <= LastVisibleLine)) ?
                                state_i.line : '0;
    end
  end

endmodule
